>>> hdl/stsg_pkg.sv
package stsg_pkg;

  // Geometry and time base.
  localparam int unsigned LINE_PIXELS = 640;
  localparam int unsigned FRAME_ROWS  = 480;
  localparam int unsigned TIME_BITS   = 48;

  // Port field widths.
  localparam int unsigned EVT_TIME_W = 48;
  localparam int unsigned PIN_W      = 4;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned COL_W      = 13;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned LEVEL_W    = 10;

  // Line numbers and level bits.
  localparam logic [PIN_W-1:0] PIN_HBLANK = 4'd8;
  localparam logic [PIN_W-1:0] PIN_VBLANK = 4'd9;
  localparam int unsigned HB_IDX = 8;
  localparam int unsigned VB_IDX = 9;
  localparam logic [LEVEL_W-1:0] HB_BIT   = LEVEL_W'(1 << 8);
  localparam logic [LEVEL_W-1:0] VB_BIT   = LEVEL_W'(1 << 9);
  localparam logic [LEVEL_W-1:0] VID_MASK = LEVEL_W'((1 << 8) - 1);

  // Result kinds.
  localparam logic KIND_SPAN  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Divider sizing: the quotient is below LINE_PIXELS.
  localparam int unsigned QUOT_W = $clog2(LINE_PIXELS);
  localparam int unsigned LP_W   = $clog2(LINE_PIXELS + 1);
  localparam int unsigned PROD_W = TIME_BITS + LP_W;
  localparam int unsigned CNT_W  = $clog2(QUOT_W + 1);

  typedef logic [TIME_BITS-1:0] time_t;

  typedef struct packed {
    logic  start;
    time_t dividend;
    time_t divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [COL_W-1:0] col;
  } div_rsp_t;

endpackage

>>> hdl/stsg_if.sv
interface stsg_in_if;
  logic                          valid;
  logic                          ready;
  logic [stsg_pkg::EVT_TIME_W-1:0] event_time;
  logic [stsg_pkg::PIN_W-1:0]      pin_number;

  modport source (output valid, output event_time, output pin_number, input ready);
  modport sink (input valid, input event_time, input pin_number, output ready);
endinterface

interface stsg_out_if;
  logic                         valid;
  logic                         ready;
  logic                         item_kind;
  logic [stsg_pkg::ROW_W-1:0]   row_index;
  logic [stsg_pkg::COL_W-1:0]   left_pixel;
  logic [stsg_pkg::COL_W-1:0]   right_pixel;
  logic [stsg_pkg::CODE_W-1:0]  video_code;
  logic [stsg_pkg::ROW_W-1:0]   frame_rows;

  modport source (output valid, output item_kind, output row_index, output left_pixel,
                  output right_pixel, output video_code, output frame_rows, input ready);
  modport sink (input valid, input item_kind, input row_index, input left_pixel,
                input right_pixel, input video_code, input frame_rows, output ready);
endinterface

>>> hdl/sync_timed_raster_span_generator.sv
// An item that draws a span runs two column divisions one after the other on the shared
// shift-subtract divider. A frame marker goes straight to the emit state, a span that
// comes out empty returns to idle without a result, and an item with nothing to draw
// leaves the block idle. One item at a time; a finished result waits in the output register.
// Reset is asynchronous and active low and clears all line state and the mode register.
module sync_timed_raster_span_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  stsg_in_if.sink             evt_i,
  stsg_out_if.source          res_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LEFT  = 4'b0010,
    S_RIGHT = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                               mode_q;
  logic [stsg_pkg::LEVEL_W-1:0]       levels_q;
  stsg_pkg::time_t                    last_q, start_q, len_q;
  logic [stsg_pkg::ROW_W-1:0]         row_q, fh_q;

  // Pending result and span job.
  logic                               res_kind_q;
  logic [stsg_pkg::ROW_W-1:0]         res_row_q, res_fh_q;
  logic [stsg_pkg::COL_W-1:0]         res_left_q, res_right_q;
  logic [stsg_pkg::CODE_W-1:0]        res_code_q;
  stsg_pkg::time_t                    e_q, len_job_q;

  // Output register.
  logic                               out_valid_q;
  logic                               o_kind_q;
  logic [stsg_pkg::ROW_W-1:0]         o_row_q, o_fh_q;
  logic [stsg_pkg::COL_W-1:0]         o_left_q, o_right_q;
  logic [stsg_pkg::CODE_W-1:0]        o_code_q;

  stsg_pkg::div_req_t                 div_req;
  stsg_pkg::div_rsp_t                 div_rsp;

  logic                               accept, pin_ok;
  stsg_pkg::time_t                    now, elapsed, span_s, len_eff;
  logic [stsg_pkg::LEVEL_W-1:0]       pin_bit;
  logic                               vb_rise, vb_fall, hb_rise, hb_fall, vid_evt;
  logic                               len_upd, draw_ok, out_load;
  logic [stsg_pkg::ROW_W-1:0]         row_odd, row_step;

  assign now     = evt_i.event_time[stsg_pkg::TIME_BITS-1:0];
  assign accept  = evt_i.valid && evt_i.ready;
  assign pin_ok  = evt_i.pin_number <= stsg_pkg::PIN_VBLANK;
  assign pin_bit = stsg_pkg::LEVEL_W'(1) << evt_i.pin_number;
  assign elapsed = now - start_q;
  assign span_s  = last_q - start_q;

  // Edge decode against the levels held before this toggle.
  assign vb_rise = (evt_i.pin_number == stsg_pkg::PIN_VBLANK) && !levels_q[stsg_pkg::VB_IDX];
  assign vb_fall = (evt_i.pin_number == stsg_pkg::PIN_VBLANK) && levels_q[stsg_pkg::VB_IDX];
  assign hb_rise = (evt_i.pin_number == stsg_pkg::PIN_HBLANK) && !levels_q[stsg_pkg::HB_IDX];
  assign hb_fall = (evt_i.pin_number == stsg_pkg::PIN_HBLANK) && levels_q[stsg_pkg::HB_IDX];
  assign vid_evt = (evt_i.pin_number < stsg_pkg::PIN_HBLANK)
                   && ((levels_q & (stsg_pkg::HB_BIT | stsg_pkg::VB_BIT)) == '0);

  assign row_odd  = mode_q ? (row_q | stsg_pkg::ROW_W'(1)) : row_q;
  assign row_step = row_q + (mode_q ? stsg_pkg::ROW_W'(2) : stsg_pkg::ROW_W'(1));

  // The line length is only measured on rows after row 0 that lie inside the previous frame.
  assign len_upd = hb_rise && (row_q != '0) && (row_q < fh_q);
  assign len_eff = len_upd ? elapsed : len_q;
  assign draw_ok = (hb_rise || vid_evt)
                   && (((levels_q & stsg_pkg::VID_MASK) != '0) || mode_q)
                   && (len_eff != '0)
                   && (row_q < stsg_pkg::ROW_W'(stsg_pkg::FRAME_ROWS));

  assign div_req.start    = (accept && pin_ok && draw_ok)
                            || (state_q == S_LEFT && div_rsp.done);
  assign div_req.dividend = (state_q == S_LEFT) ? e_q : span_s;
  assign div_req.divisor  = (state_q == S_LEFT) ? len_job_q : len_eff;

  stsg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && pin_ok) begin
          if (vb_rise) begin
            state_d = S_EMIT;
          end else if (draw_ok) begin
            state_d = S_LEFT;
          end
        end
      end
      S_LEFT: begin
        if (div_rsp.done) begin
          state_d = S_RIGHT;
        end
      end
      S_RIGHT: begin
        if (div_rsp.done) begin
          state_d = (res_left_q < div_rsp.col) ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      levels_q    <= '0;
      last_q      <= '0;
      start_q     <= '0;
      len_q       <= '0;
      row_q       <= '0;
      fh_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept && pin_ok) begin
        levels_q <= levels_q ^ pin_bit;
        last_q   <= now;
        if (vb_rise) begin
          row_q <= row_odd;
          fh_q  <= row_odd;
        end else if (hb_rise) begin
          len_q <= len_eff;
          row_q <= row_step;
        end else if (vb_fall) begin
          row_q <= (mode_q && (elapsed > len_q)) ? stsg_pkg::ROW_W'(1) : '0;
        end else if (hb_fall) begin
          start_q <= now;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept && pin_ok) begin
      if (vb_rise) begin
        res_kind_q  <= stsg_pkg::KIND_FRAME;
        res_row_q   <= '0;
        res_left_q  <= '0;
        res_right_q <= '0;
        res_code_q  <= '0;
        res_fh_q    <= row_odd;
      end else begin
        res_kind_q <= stsg_pkg::KIND_SPAN;
        res_row_q  <= row_q;
        res_code_q <= levels_q[stsg_pkg::CODE_W-1:0];
        res_fh_q   <= fh_q;
        e_q        <= elapsed;
        len_job_q  <= len_eff;
      end
    end
    if (state_q == S_LEFT && div_rsp.done) begin
      res_left_q <= div_rsp.col;
    end
    if (state_q == S_RIGHT && div_rsp.done) begin
      res_right_q <= div_rsp.col;
    end
    if (out_load) begin
      o_kind_q  <= res_kind_q;
      o_row_q   <= res_row_q;
      o_left_q  <= res_left_q;
      o_right_q <= res_right_q;
      o_code_q  <= res_code_q;
      o_fh_q    <= res_fh_q;
    end
  end

  assign evt_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.item_kind   = o_kind_q;
  assign res_o.row_index   = o_row_q;
  assign res_o.left_pixel  = o_left_q;
  assign res_o.right_pixel = o_right_q;
  assign res_o.video_code  = o_code_q;
  assign res_o.frame_rows  = o_fh_q;

`ifndef SYNTHESIS
  a_span_cols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_kind_q == stsg_pkg::KIND_SPAN |->
      o_left_q < o_right_q && o_right_q <= stsg_pkg::COL_W'(stsg_pkg::LINE_PIXELS))
    else $error("span columns out of order or beyond the line");

  a_span_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_kind_q == stsg_pkg::KIND_SPAN |->
      o_row_q < stsg_pkg::ROW_W'(stsg_pkg::FRAME_ROWS))
    else $error("span row beyond the frame");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && o_kind_q == stsg_pkg::KIND_FRAME |->
      o_row_q == '0 && o_left_q == '0 && o_right_q == '0 && o_code_q == '0)
    else $error("frame marker carries span fields");

  a_left_then_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LEFT && div_rsp.done |=> state_q == S_RIGHT)
    else $error("right column division did not follow the left one");

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output loaded outside the emit state");
`endif

endmodule

>>> hdl/stsg_div.sv
module stsg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stsg_pkg::div_req_t req_i,
  output stsg_pkg::div_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_LOAD = 4'b0100,
    D_STEP = 4'b1000
  } dstate_e;

  dstate_e dstate_q, dstate_d;
  logic [stsg_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           done_q, done_d;
  stsg_pkg::time_t                a_q, len_q, rem_q;
  logic                           sat_q;
  logic [stsg_pkg::PROD_W-1:0]    prod_q;
  logic [stsg_pkg::QUOT_W-1:0]    lo_q, quot_q;
  logic [stsg_pkg::TIME_BITS:0]   trial, diff;
  logic                           fits;
  stsg_pkg::time_t                rem_next;

  // One restoring step: the partial remainder stays below the divisor.
  assign trial    = {rem_q, lo_q[stsg_pkg::QUOT_W-1]};
  assign fits     = trial >= {1'b0, len_q};
  assign diff     = trial - {1'b0, len_q};
  assign rem_next = fits ? diff[stsg_pkg::TIME_BITS-1:0] : trial[stsg_pkg::TIME_BITS-1:0];

  always_comb begin
    dstate_d = dstate_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    case (dstate_q)
      D_IDLE: begin
        if (req_i.start) begin
          dstate_d = D_MUL;
        end
      end
      D_MUL: begin
        dstate_d = D_LOAD;
      end
      D_LOAD: begin
        dstate_d = D_STEP;
        cnt_d    = stsg_pkg::CNT_W'(stsg_pkg::QUOT_W);
      end
      D_STEP: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == stsg_pkg::CNT_W'(1)) begin
          dstate_d = D_IDLE;
          done_d   = 1'b1;
        end
      end
      default: begin
        dstate_d = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstate_q <= D_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      dstate_q <= dstate_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (dstate_q)
      D_IDLE: begin
        if (req_i.start) begin
          a_q   <= req_i.dividend;
          len_q <= req_i.divisor;
          sat_q <= req_i.dividend >= req_i.divisor;
        end
      end
      D_MUL: begin
        prod_q <= stsg_pkg::PROD_W'(a_q) * stsg_pkg::PROD_W'(stsg_pkg::LINE_PIXELS);
      end
      D_LOAD: begin
        rem_q  <= stsg_pkg::TIME_BITS'(prod_q >> stsg_pkg::QUOT_W);
        lo_q   <= prod_q[stsg_pkg::QUOT_W-1:0];
        quot_q <= '0;
      end
      D_STEP: begin
        rem_q  <= rem_next;
        lo_q   <= {lo_q[stsg_pkg::QUOT_W-2:0], 1'b0};
        quot_q <= {quot_q[stsg_pkg::QUOT_W-2:0], fits};
      end
      default: begin
        rem_q <= rem_q;
      end
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.col  = sat_q ? stsg_pkg::COL_W'(stsg_pkg::LINE_PIXELS)
                            : stsg_pkg::COL_W'(quot_q);

endmodule

>>> tb/sv/raster_span_checker.sv
`timescale 1ns / 100ps

module raster_span_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  stsg_in_if    evt_i,
  stsg_out_if   res_i,
  output int    fail_count_o,
  output int    backlog_o,
  output int    span_count_o,
  output int    marker_count_o,
  output int    toggle_count_o
);
  import stsg_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  left_col;
    logic [COL_W-1:0]  right_col;
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  rows;
  } raster_item_t;

  // Spans and frame markers owed by the block, oldest first.
  raster_item_t queued_items[$];
  raster_item_t got;

  logic               interlaced;
  logic [LEVEL_W-1:0] levels;
  time_t              last_t;
  time_t              line_t0;
  time_t              line_len;
  logic [ROW_W-1:0]   row_pos;
  logic [ROW_W-1:0]   frame_h;

  task automatic flag_mismatch(input string what);
    fail_count_o++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Exact floor(offset * LINE_PIXELS / len), saturated at the line width.
  function automatic logic [COL_W-1:0] pixel_col(input time_t offset, input time_t len);
    logic [63:0] prod;
    prod = 64'(offset) * 64'(LINE_PIXELS);
    if (offset >= len) return COL_W'(LINE_PIXELS);
    return COL_W'(prod / 64'(len));
  endfunction

  function automatic void close_span(input time_t now);
    raster_item_t item;
    item.kind = KIND_SPAN;
    item.row  = row_pos;
    item.code = CODE_W'(levels & VID_MASK);
    item.rows = frame_h;
    if (item.code == '0 && !interlaced) return;
    if (line_len == '0 || row_pos >= ROW_W'(FRAME_ROWS)) return;
    item.left_col  = pixel_col(last_t - line_t0, line_len);
    item.right_col = pixel_col(now - line_t0, line_len);
    if (item.left_col >= item.right_col) return;
    queued_items.push_back(item);
  endfunction

  // Decisions use the line levels from before this toggle.
  function automatic void advance_raster(input time_t now, input logic [PIN_W-1:0] pin);
    time_t        elapsed;
    raster_item_t mark;
    if (pin > PIN_VBLANK) return;
    elapsed = now - line_t0;
    if (pin == PIN_VBLANK && !levels[VB_IDX]) begin
      if (interlaced && !row_pos[0]) row_pos = row_pos + 1'b1;
      frame_h   = row_pos;
      mark      = '0;
      mark.kind = KIND_FRAME;
      mark.rows = frame_h;
      queued_items.push_back(mark);
    end else if (pin == PIN_HBLANK && !levels[HB_IDX]) begin
      if (row_pos != '0 && row_pos < frame_h) line_len = elapsed;
      close_span(now);
      row_pos = row_pos + (interlaced ? ROW_W'(2) : ROW_W'(1));
    end else if (pin == PIN_VBLANK) begin
      // In interlaced mode a long vertical blank marks the odd field.
      row_pos = (interlaced && elapsed > line_len) ? ROW_W'(1) : '0;
    end else if (pin == PIN_HBLANK) begin
      line_t0 = now;
    end else if ((levels & (HB_BIT | VB_BIT)) == '0) begin
      close_span(now);
    end
    levels = levels ^ (LEVEL_W'(1) << pin);
    last_t = now;
  endfunction

  task automatic match_result(input raster_item_t item);
    raster_item_t want;
    if (queued_items.size() == 0) begin
      flag_mismatch($sformatf("unexpected result kind=%0d row=%0d cols=%0d..%0d code=%02h",
                              item.kind, item.row, item.left_col, item.right_col, item.code));
      return;
    end
    want = queued_items.pop_front();
    if (item.kind !== want.kind || item.row !== want.row ||
        item.left_col !== want.left_col || item.right_col !== want.right_col ||
        item.code !== want.code || item.rows !== want.rows) begin
      flag_mismatch($sformatf(
        "got kind=%0d row=%0d cols=%0d..%0d code=%02h rows=%0d, want %0d %0d %0d..%0d %02h %0d",
        item.kind, item.row, item.left_col, item.right_col, item.code, item.rows,
        want.kind, want.row, want.left_col, want.right_col, want.code, want.rows));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interlaced     = 1'b0;
      levels         = '0;
      last_t         = '0;
      line_t0        = '0;
      line_len       = '0;
      row_pos        = '0;
      frame_h        = '0;
      fail_count_o   = 0;
      span_count_o   = 0;
      marker_count_o = 0;
      toggle_count_o = 0;
      queued_items.delete();
    end else begin
      // A result leaving in the same cycle as a new toggle belongs to an older toggle.
      if (res_i.valid && res_i.ready) begin
        got.kind      = res_i.item_kind;
        got.row       = res_i.row_index;
        got.left_col  = res_i.left_pixel;
        got.right_col = res_i.right_pixel;
        got.code      = res_i.video_code;
        got.rows      = res_i.frame_rows;
        match_result(got);
        if (got.kind == KIND_FRAME) marker_count_o++;
        else span_count_o++;
      end
      if (cfg_we_i) interlaced = cfg_wdata_i;
      if (evt_i.valid && evt_i.ready) begin
        advance_raster(evt_i.event_time, evt_i.pin_number);
        if (evt_i.pin_number <= PIN_VBLANK) toggle_count_o++;
      end
    end
    backlog_o = queued_items.size();
  end

endmodule

>>> tb/sv/tb_sync_timed_raster_span_generator.sv
`timescale 1ns / 100ps

module tb_sync_timed_raster_span_generator;
  import stsg_pkg::*;

  localparam int unsigned TOGGLE_TARGET = 1550;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned TALL_LINES    = 250;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  cfg_we    = 1'b0;
  logic  cfg_wdata = 1'b0;
  logic  calm      = 1'b0;
  logic  hb_high   = 1'b0;
  logic  vb_high   = 1'b0;
  time_t stamp     = '0;
  int    sent_toggles = 0;
  int    mode_writes  = 0;
  int    phase        = 0;
  int    fail_count;
  int    backlog;
  int    span_count;
  int    marker_count;
  int    toggle_count;

  stsg_in_if  evt_if ();
  stsg_out_if res_if ();

  sync_timed_raster_span_generator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .evt_i       (evt_if),
    .res_o       (res_if)
  );

  raster_span_checker chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .evt_i          (evt_if),
    .res_i          (res_if),
    .fail_count_o   (fail_count),
    .backlog_o      (backlog),
    .span_count_o   (span_count),
    .marker_count_o (marker_count),
    .toggle_count_o (toggle_count)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    res_if.ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  function automatic time_t rnd_upto(input time_t max);
    time_t r;
    r = time_t'({$urandom, $urandom});
    if (max == '0) return '0;
    if (max == '1) return r;
    return r % (max + 1'b1);
  endfunction

  function automatic time_t pick_period();
    case ($urandom_range(0, 9))
      0:       return 1 + rnd_upto(20);
      1:       return time_t'({8'($urandom_range(0, 255)), $urandom}) + 1;
      default: return time_t'($urandom_range(600, 8000));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_toggle(input time_t t, input logic [PIN_W-1:0] pin);
    while (!calm && $urandom_range(0, 99) < 15) begin
      evt_if.valid <= 1'b0;
      @(negedge clk);
    end
    evt_if.valid      <= 1'b1;
    evt_if.event_time <= t;
    evt_if.pin_number <= pin;
    @(posedge clk);
    while (!evt_if.ready) @(posedge clk);
    @(negedge clk);
    if (pin == PIN_HBLANK) hb_high = ~hb_high;
    if (pin == PIN_VBLANK) vb_high = ~vb_high;
    if (pin <= PIN_VBLANK) sent_toggles++;
  endtask

  // Lets every owed result out, then gives an item without a result time to finish.
  task automatic settle();
    evt_if.valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input logic interlace);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= interlace;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mode_writes++;
  endtask

  task automatic send_line(input time_t period, input int unsigned toggles);
    time_t       t0;
    time_t       off;
    time_t       step;
    time_t       tail;
    int unsigned i;
    if (!hb_high) begin
      send_toggle(stamp, PIN_HBLANK);
      stamp = stamp + 1'b1;
    end
    t0 = stamp;
    send_toggle(t0, PIN_HBLANK);
    step = period / time_t'(toggles + 1);
    off  = '0;
    for (i = 0; i < toggles; i++) begin
      off = off + step / 2 + rnd_upto(step);
      send_toggle(t0 + off, PIN_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 49) == 0) send_toggle(rnd_upto('1), PIN_W'($urandom_range(0, 15)));
    end
    tail = period - period / 16 + rnd_upto(period / 8);
    if ($urandom_range(0, 24) == 0) tail = rnd_upto(period);
    // Now and then the end of the line is dropped, so two lines run together.
    if ($urandom_range(0, 29) != 0) send_toggle(t0 + tail, PIN_HBLANK);
    stamp = t0 + tail + 1'b1 + rnd_upto(period / 8);
  endtask

  task automatic send_frame(input int unsigned rows, input time_t period,
                            input int unsigned max_toggles);
    int unsigned r;
    if (vb_high) begin
      send_toggle(stamp, PIN_VBLANK);
      stamp += 3;
    end
    send_toggle(stamp, PIN_VBLANK);
    // The blank length decides the field in interlaced mode.
    stamp = stamp + rnd_upto(period);
    if ($urandom_range(0, 19) != 0) send_toggle(stamp, PIN_VBLANK);
    stamp = stamp + 1'b1 + rnd_upto(period / 4);
    for (r = 0; r < rows; r++) send_line(period, $urandom_range(0, max_toggles));
  endtask

  initial begin
    evt_if.valid      = 1'b0;
    evt_if.event_time = '0;
    evt_if.pin_number = '0;
    res_if.ready      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_mode(1'b0);

    // Progressive: zero line length, pins above nine, a measured line,
    // an empty span, saturation at the line end and a time wrap.
    send_toggle(48'd5, PIN_W'(0));
    send_toggle(48'd7, PIN_W'(10));
    send_toggle(48'd100, PIN_HBLANK);
    send_toggle(48'd200, PIN_HBLANK);
    send_toggle(48'd1200, PIN_HBLANK);
    send_toggle(48'd1300, PIN_VBLANK);
    send_toggle(48'd1400, PIN_VBLANK);
    send_toggle(48'd1500, PIN_HBLANK);
    send_toggle(48'd2500, PIN_HBLANK);
    send_toggle(48'd2600, PIN_HBLANK);
    send_toggle(48'd2850, PIN_W'(7));
    send_toggle(48'd3600, PIN_HBLANK);
    send_toggle(48'd3700, PIN_HBLANK);
    send_toggle(48'd3700, PIN_W'(0));
    send_toggle(48'd4699, PIN_W'(1));
    send_toggle(48'd5700, PIN_W'(2));
    send_toggle(48'd6700, PIN_HBLANK);
    send_toggle(48'd6800, PIN_VBLANK);
    send_toggle(48'd6900, PIN_VBLANK);
    send_toggle(48'hFFFF_FFFF_FED4, PIN_HBLANK);
    send_toggle(48'hFFFF_FFFF_FF38, PIN_W'(3));
    send_toggle(48'd700, PIN_HBLANK);

    // Interlaced: odd field from a long blank and a span at video level zero.
    set_mode(1'b1);
    send_toggle(48'd10000, PIN_VBLANK);
    send_toggle(48'd10010, PIN_W'(1));
    send_toggle(48'd10020, PIN_W'(2));
    send_toggle(48'd10030, PIN_W'(3));
    send_toggle(48'd10040, PIN_W'(7));
    send_toggle(48'd20000, PIN_VBLANK);
    send_toggle(48'd20100, PIN_HBLANK);
    send_toggle(48'd21100, PIN_HBLANK);

    while (sent_toggles < TOGGLE_TARGET) begin
      phase++;
      if (phase == 2) set_mode(1'b1);
      else if (phase < 5) set_mode(phase[0]);
      else set_mode(1'($urandom_range(0, 1)));
      calm  = (phase == 4);
      stamp = time_t'({16'($urandom_range(0, 65535)), $urandom});
      // One interlaced frame runs past the last visible row.
      if (phase == 2) send_frame(TALL_LINES, 48'd800, 1);
      else repeat (4) send_frame($urandom_range(2, 12), pick_period(), 4);
    end
    calm = 1'b0;
    settle();

    $display("Covered %0d line toggles over %0d mode settings, one frame past row %0d.",
             toggle_count, mode_writes, FRAME_ROWS);
    $display("Checked %0d pixel spans and %0d frame markers, %0d mismatches.",
             span_count, marker_count, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results still owed.", backlog);
    $display("FAILURE");
    $finish;
  end

endmodule
